FILE: design/gcd_pkg.sv
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared constants, a lookup table and types for the haversine pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Number of CORDIC micro-rotations per sine/cosine or arctangent.
  localparam int CORDIC_STEPS = 24;
  // Digit-by-digit square root steps (one result bit per step).
  localparam int SQRT_STEPS = 32;

  // Datapath widths.
  localparam int CW = 34;  // CORDIC x, y and angle
  localparam int SW = 63;  // square root remainder and partial root

  // Q30 fixed-point constants.
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] Q30_ONE  = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN = 34'sd2147483648;

  // Reciprocal of 45, floor(2^37 / 45), for splitting an angle magnitude.
  localparam logic [31:0] RECIP45       = 32'd3054198966;
  localparam int          RECIP45_SHIFT = 37;
  // Reciprocal of 90, ceil(2^20 / 90), exact for the narrow remainder path.
  localparam logic [13:0] RECIP90       = 14'd11651;
  localparam int          RECIP90_SHIFT = 20;

  // Circumference in centimeters and the output saturation limit.
  localparam logic [31:0] CIRC_CM      = 32'd4003017359;
  localparam logic [30:0] HALF_CIRC_CM = 31'd2001508680;

  // Register stages from the input register to the last scaling stage.
  localparam int PIPE_DEPTH = 42 + 2 * CORDIC_STEPS;

  // Arctangent table, atan(2^-i) in binary angle units (2^32 per turn).
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // CORDIC operating mode of one cell.
  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_e;

  // Data handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 tag;  // quadrant flip or zero-angle flag
  } cordic_t;

  // Data handed from one square root cell to the next.
  typedef struct packed {
    logic [SW-1:0] v;
    logic [SW-1:0] res;
  } sqrt_t;

endpackage

FILE: design/gcd_if.sv
// ----------------------------------------------------------------------------
// Great-circle distance channel interfaces
// Valid/ready channels for coordinate pairs and for distances.
// ----------------------------------------------------------------------------

// Coordinate pair channel.
interface gcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [29:0] lat_a;
  logic signed [30:0] lng_a;
  logic signed [29:0] lat_b;
  logic signed [30:0] lng_b;

  modport source (output valid, output lat_a, output lng_a, output lat_b,
                  output lng_b, input ready);
  modport sink (input valid, input lat_a, input lng_a, input lat_b,
                input lng_b, output ready);
endinterface

// Distance channel.
interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] distance_cm;

  modport source (output valid, output distance_cm, input ready);
  modport sink (input valid, input distance_cm, output ready);
endinterface

FILE: design/gcd_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered micro-rotation, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module gcd_cordic_cell import gcd_pkg::*; (
  input  logic         clk_i,
  input  logic         en_i,
  input  cordic_mode_e mode_i,
  input  logic [4:0]   step_i,
  input  cordic_t      d_i,
  output cordic_t      d_o
);

  logic signed [CW-1:0] xs, ys, dx, dy, da;
  logic                 pos;
  cordic_t              d_d, d_q;

  // Rotation steers on the residual angle, vectoring on the sign of y.
  always_comb begin
    xs = d_i.x;
    ys = d_i.y;
    dx = ys >>> step_i;
    dy = xs >>> step_i;
    da = CW'(ATAN_TAB[step_i]);
    unique case (mode_i)
      CORDIC_ROTATE: pos = !d_i.z[CW-1];
      CORDIC_VECTOR: pos = d_i.y[CW-1] || (d_i.y == '0);
    endcase
    d_d = d_i;
    if (pos) begin
      d_d.x = xs - dx;
      d_d.y = ys + dy;
      d_d.z = d_i.z - da;
    end else begin
      d_d.x = xs + dx;
      d_d.y = ys - dy;
      d_d.z = d_i.z + da;
    end
  end

  // Hand the result to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

FILE: design/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One registered step of a restoring digit-by-digit floor square root.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell import gcd_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [4:0] step_i,
  input  sqrt_t      d_i,
  output sqrt_t      d_o
);

  logic [SW-1:0] bitv, trial;
  sqrt_t         d_d, d_q;

  // Try the next result bit and keep it if the remainder allows.
  always_comb begin
    bitv  = {1'b1, {(SW-1){1'b0}}} >> {step_i, 1'b0};
    trial = d_i.res + bitv;
    if (d_i.v >= trial) begin
      d_d.v   = d_i.v - trial;
      d_d.res = (d_i.res >> 1) + bitv;
    end else begin
      d_d.v   = d_i.v;
      d_d.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

FILE: design/great_circle_distance.sv
// ----------------------------------------------------------------------------
// Great-circle distance
// Haversine distance between two coordinates, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// - in_i carries one coordinate pair per transaction (latitudes and
//   longitudes in units of 2^-22 degree); out_o carries the distance in
//   centimeters, saturated at half the circumference.
// - The pipeline accepts one transaction every cycle while it advances. It holds
//   PIPE_DEPTH + 1 register stages (91 with 24 CORDIC steps): the input register,
//   two angle conversion stages, four parallel chains of CORDIC_STEPS rotation
//   cells, five stages for the haversine products and sum, two chains of 32
//   square root cells, one chain of CORDIC_STEPS vectoring cells, two scaling
//   stages and the output register. The input register loads at the accepting
//   edge; the result then moves through each stage to the output register.
// - The whole pipeline advances whenever the output register is empty or
//   being taken, so in_i.ready follows out_o.ready; a stalled receiver
//   freezes every stage and the result waiting in the output register.
// - Reset clears all valid bits; no result is presented until an input
//   transaction has passed through.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  gcd_in_if.sink       in_i,
  gcd_out_if.source    out_o
);

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_q;

  // Input register.
  logic signed [29:0] la_q, lb_q;
  logic signed [30:0] na_q, nb_q;

  // Angle conversion lanes: latitude delta, longitude delta, lat a, lat b.
  logic signed [31:0] ang [4];
  logic [30:0]        mag [4];
  logic [62:0]        mprod [4];
  logic               neg_q [4];
  logic [30:0]        mag_q [4];
  logic [25:0]        h0_q [4];
  logic [31:0]        bam_q [4];

  // CORDIC chains.
  cordic_t rot_c [4][CORDIC_STEPS+1];
  cordic_t rot_init [4];
  cordic_t vec_c [CORDIC_STEPS+1];

  // Product stages.
  logic signed [CW-1:0]   s1_q, s2_q, c1_q, c2_q;
  logic signed [CW-1:0]   pss_q, pc_q, s2m1_q, t2_q, s2m2_q, pssm2_q, t3_q, pssm3_q;
  logic signed [2*CW-1:0] pr_ss, pr_cc, pr_t2, pr_t3;
  logic signed [CW:0]     asum;
  logic [30:0]            a_d, a_q;

  // Square root chains: square root of a and of one minus a.
  sqrt_t sq_c [2][SQRT_STEPS+1];

  // Final scaling.
  logic signed [CW:0] z2;
  logic [31:0]        cb_d, cb_q;
  logic [63:0]        dprod;
  logic [31:0]        dq_q;
  logic               out_valid_q;
  logic [30:0]        dist_q;

  // The pipeline moves when the output register can take a new result.
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[PIPE_DEPTH-2:0], in_i.valid};
      out_valid_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // Capture the coordinate pair.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      la_q <= in_i.lat_a;
      na_q <= in_i.lng_a;
      lb_q <= in_i.lat_b;
      nb_q <= in_i.lng_b;
    end
  end

  // Signed angles, magnitudes and a first quotient by 45.
  always_comb begin
    ang[0] = 32'(lb_q) - 32'(la_q);
    ang[1] = 32'(nb_q) - 32'(na_q);
    ang[2] = 32'(la_q);
    ang[3] = 32'(lb_q);
    for (int l = 0; l < 4; l++) begin
      mag[l]   = ang[l][31] ? 31'(-ang[l]) : 31'(ang[l]);
      mprod[l] = 63'(mag[l]) * 63'(RECIP45);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        neg_q[l] <= ang[l][31];
        mag_q[l] <= mag[l];
        h0_q[l]  <= mprod[l][62:RECIP45_SHIFT];
      end
    end
  end

  // Correct the quotient, round the remainder and form binary angles.
  // Deltas are halved angles (64/45 per unit), latitudes full (128/45).
  always_ff @(posedge clk_i) begin
    logic [6:0]  r0;
    logic        rr;
    logic [25:0] h;
    logic [5:0]  r;
    logic [13:0] n;
    logic [27:0] fp;
    logic [31:0] q;
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        r0 = 7'(mag_q[l] - 31'(31'(h0_q[l]) * 31'd45));
        rr = (r0 >= 7'd45);
        h  = h0_q[l] + 26'(rr);
        r  = rr ? 6'(r0 - 7'd45) : 6'(r0);
        n  = (l >= 2) ? ({r, 8'd0} + 14'd45) : (14'({r, 7'd0}) + 14'd45);
        fp = 28'(n) * 28'(RECIP90);
        q  = ((l >= 2) ? 32'({h, 7'd0}) : 32'({h, 6'd0}))
             + 32'(fp[27:RECIP90_SHIFT]);
        bam_q[l] <= neg_q[l] ? -q : q;
      end
    end
  end

  // Fold the angle into the right half plane, remembering the flip.
  always_comb begin
    logic signed [CW-1:0] t;
    for (int l = 0; l < 4; l++) begin
      t = CW'($signed(bam_q[l]));
      rot_init[l].x   = GAIN_Q30;
      rot_init[l].y   = '0;
      rot_init[l].tag = 1'b0;
      if (t > Q30_ONE) begin
        t = t - HALF_TURN;
        rot_init[l].tag = 1'b1;
      end else if (t < -Q30_ONE) begin
        t = t + HALF_TURN;
        rot_init[l].tag = 1'b1;
      end
      rot_init[l].z = t;
    end
  end

  // Four rotation chains for the sines and cosines.
  for (genvar l = 0; l < 4; l++) begin : g_rot
    assign rot_c[l][0] = rot_init[l];
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      gcd_cordic_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (adv),
        .mode_i (CORDIC_ROTATE),
        .step_i (5'(g)),
        .d_i    (rot_c[l][g]),
        .d_o    (rot_c[l][g+1])
      );
    end
  end

  // Undo the quadrant flip and the multiply chain of the haversine term.
  always_comb begin
    pr_ss = s1_q * s1_q;
    pr_cc = c1_q * c2_q;
    pr_t2 = pc_q * s2m1_q;
    pr_t3 = t2_q * s2m2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= rot_c[0][CORDIC_STEPS].tag ? -rot_c[0][CORDIC_STEPS].y
                                            : rot_c[0][CORDIC_STEPS].y;
      s2_q    <= rot_c[1][CORDIC_STEPS].tag ? -rot_c[1][CORDIC_STEPS].y
                                            : rot_c[1][CORDIC_STEPS].y;
      c1_q    <= rot_c[2][CORDIC_STEPS].tag ? -rot_c[2][CORDIC_STEPS].x
                                            : rot_c[2][CORDIC_STEPS].x;
      c2_q    <= rot_c[3][CORDIC_STEPS].tag ? -rot_c[3][CORDIC_STEPS].x
                                            : rot_c[3][CORDIC_STEPS].x;
      pss_q   <= CW'(pr_ss >>> 30);
      pc_q    <= CW'(pr_cc >>> 30);
      s2m1_q  <= s2_q;
      t2_q    <= CW'(pr_t2 >>> 30);
      s2m2_q  <= s2m1_q;
      pssm2_q <= pss_q;
      t3_q    <= CW'(pr_t3 >>> 30);
      pssm3_q <= pssm2_q;
      a_q     <= a_d;
    end
  end

  // Sum and clamp a to the unit interval.
  always_comb begin
    asum = (CW+1)'(pssm3_q) + (CW+1)'(t3_q);
    if (asum[CW]) begin
      a_d = '0;
    end else if (asum > (CW+1)'(Q30_ONE)) begin
      a_d = 31'(Q30_ONE);
    end else begin
      a_d = 31'(asum);
    end
  end

  // Square root chains.
  assign sq_c[0][0].v   = SW'(a_q) << 30;
  assign sq_c[0][0].res = '0;
  assign sq_c[1][0].v   = SW'(31'(Q30_ONE) - a_q) << 30;
  assign sq_c[1][0].res = '0;

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
      gcd_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (adv),
        .step_i (5'(g)),
        .d_i    (sq_c[l][g]),
        .d_o    (sq_c[l][g+1])
      );
    end
  end

  // Vectoring chain for the central angle; a zero sine means zero angle.
  assign vec_c[0].x   = CW'(sq_c[1][SQRT_STEPS].res[30:0]);
  assign vec_c[0].y   = CW'(sq_c[0][SQRT_STEPS].res[30:0]);
  assign vec_c[0].z   = '0;
  assign vec_c[0].tag = (sq_c[0][SQRT_STEPS].res[30:0] == '0);

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    gcd_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .mode_i (CORDIC_VECTOR),
      .step_i (5'(g)),
      .d_i    (vec_c[g]),
      .d_o    (vec_c[g+1])
    );
  end

  // Double and clamp the angle, then scale to centimeters.
  always_comb begin
    z2 = (CW+1)'(vec_c[CORDIC_STEPS].z) <<< 1;
    if (vec_c[CORDIC_STEPS].tag || z2[CW]) begin
      cb_d = '0;
    end else if (z2 > (CW+1)'(HALF_TURN)) begin
      cb_d = 32'h8000_0000;
    end else begin
      cb_d = 32'(z2);
    end
    dprod = 64'(cb_q) * 64'(CIRC_CM) + 64'h8000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cb_q   <= cb_d;
      dq_q   <= dprod[63:32];
      dist_q <= (dq_q > 32'(HALF_CIRC_CM)) ? HALF_CIRC_CM : dq_q[30:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.distance_cm = dist_q;

endmodule

FILE: design/gcd_checker.sv
// ----------------------------------------------------------------------------
// Great-circle distance checker
// Port-level assertions on the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module gcd_checker import gcd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [30:0] distance_cm_i
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_cm_i))
    else $error("stalled result changed");

  // Results never exceed half the circumference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> distance_cm_i <= HALF_CIRC_CM)
    else $error("distance above saturation limit");

  // Input is taken exactly when the output stage can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stage");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .distance_cm_i (out_o.distance_cm)
);

FILE: verif/tb_great_circle_distance.sv
// ----------------------------------------------------------------------------
// Great-circle distance testbench
// Drives coordinate pairs with random gaps, predicts each distance with a
// fixed-point haversine model and checks results in order.
// ----------------------------------------------------------------------------
module tb_great_circle_distance;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1850;
  localparam int LATENCY = gcd_pkg::PIPE_DEPTH + 1;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint LAT_MAX = 377487360;
  localparam longint LNG_MAX = 754974720;
  localparam longint CIRC = 64'd4003017359;
  localparam longint HALF_CIRC = 2001508680;
  localparam longint Q30 = 1073741824;

  typedef struct packed {
    logic signed [29:0] lat_a;
    logic signed [30:0] lng_a;
    logic signed [29:0] lat_b;
    logic signed [30:0] lng_b;
  } coord_pair_t;

  logic clk_i;
  logic rst_ni;
  gcd_in_if  pair_if ();
  gcd_out_if dist_if ();

  great_circle_distance dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_if.sink),
    .out_o (dist_if.source)
  );

  coord_pair_t pending_pairs[$];
  logic [30:0] expected_dist[$];
  bit          stim_done;
  int          mismatches;
  longint      cycles;
  int          hold_off;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Arithmetic shift right, rounding toward minus infinity.
  function automatic longint sar(longint v, int s);
    return v >>> s;
  endfunction

  // Input units times mul/45 to a binary angle, rounded half away from zero.
  function automatic logic [31:0] units_to_bam(longint units, longint mul);
    longint mag;
    longint q;
    mag = (units < 0) ? -units : units;
    q = (mag * mul * 2 + 45) / 90;
    if (units < 0) q = -q;
    return q[31:0];
  endfunction

  // Rotation-mode CORDIC: sine and cosine in Q30.
  function automatic void cordic_sincos(input logic [31:0] b, output longint s,
                                        output longint c);
    longint t;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit flip;
    t = longint'(signed'(b));
    x = gcd_pkg::GAIN_Q30;
    y = 0;
    flip = 0;
    if (t > Q30) begin
      t -= 64'sd2147483648;
      flip = 1;
    end else if (t < -Q30) begin
      t += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
      dx = sar(y, i);
      dy = sar(x, i);
      if (t >= 0) begin
        x -= dx; y += dy; t -= longint'(gcd_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; t += longint'(gcd_pkg::ATAN_TAB[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Vectoring-mode CORDIC angle of a first-quadrant vector.
  function automatic longint cordic_angle(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
      dx = sar(y, i);
      dy = sar(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [30:0] haversine_cm(coord_pair_t p);
    longint la, na, lb, nb;
    longint s1, s2, c1, c2, unused, a, z, ry, rx;
    longint unsigned d;
    la = p.lat_a; na = p.lng_a; lb = p.lat_b; nb = p.lng_b;
    cordic_sincos(units_to_bam(lb - la, 64), s1, unused);
    cordic_sincos(units_to_bam(nb - na, 64), s2, unused);
    cordic_sincos(units_to_bam(la, 128), unused, c1);
    cordic_sincos(units_to_bam(lb, 128), unused, c2);
    a = sar(s1 * s1, 30) + sar(sar(sar(c1 * c2, 30) * s2, 30) * s2, 30);
    if (a < 0) a = 0;
    if (a > Q30) a = Q30;
    ry = floor_sqrt(longint'(a) << 30);
    rx = floor_sqrt(longint'(Q30 - a) << 30);
    z = 2 * cordic_angle(ry, rx);
    if (z < 0) z = 0;
    if (z > 64'sd2147483648) z = 64'sd2147483648;
    d = (longint'(z) * CIRC + 64'd2147483648) >> 32;
    if (d > HALF_CIRC) d = HALF_CIRC;
    return d[30:0];
  endfunction

  function automatic coord_pair_t make_pair(longint la, longint na, longint lb, longint nb);
    coord_pair_t p;
    p.lat_a = la[29:0]; p.lng_a = na[30:0]; p.lat_b = lb[29:0]; p.lng_b = nb[30:0];
    return p;
  endfunction

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(32'(2 * lim))) - lim;
  endfunction

  // Append a pair to the driver's pending queue.
  function automatic void add_pair(coord_pair_t p);
    pending_pairs = {pending_pairs, p};
  endfunction

  // Stimulus: directed extremes, then mostly in-range pairs with some
  // full-width raw values, near-coincident and antipodal points.
  initial begin
    coord_pair_t p;
    longint la, na;
    add_pair(make_pair(0, 0, 0, 0));
    add_pair(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
    add_pair(make_pair(0, -LNG_MAX, 0, LNG_MAX));
    add_pair(make_pair(0, 0, 0, LNG_MAX));
    add_pair(make_pair(LAT_MAX, LNG_MAX, LAT_MAX, -LNG_MAX));
    add_pair(make_pair(-LAT_MAX, -LNG_MAX, -LAT_MAX, -LNG_MAX));
    add_pair(make_pair(123456, 7890123, 123456, 7890123));
    add_pair(make_pair(0, 0, 1, 0));
    add_pair(make_pair(0, 0, 0, 1));
    add_pair(make_pair(0, 0, 0, -1));
    add_pair(make_pair(-(1 << 29), -(1 << 30), (1 << 29) - 1, (1 << 30) - 1));
    add_pair(make_pair((1 << 29) - 1, (1 << 30) - 1, -(1 << 29), -(1 << 30)));
    add_pair(make_pair(-1, -1, -1, -1));
    add_pair(make_pair(LAT_MAX, 0, 0, 0));
    add_pair(make_pair(209715200, 377487360, -209715200, -377487360));
    for (int n = 0; n < NUM_RANDOM; n++) begin
      case ($urandom_range(9))
        0: p = coord_pair_t'({$urandom, $urandom, $urandom, $urandom});
        1: begin
          la = rand_span(LAT_MAX); na = rand_span(LNG_MAX);
          p = make_pair(la, na, la + rand_span(64), na + rand_span(64));
        end
        2: begin
          la = rand_span(LAT_MAX); na = rand_span(LNG_MAX);
          p = make_pair(la, na, -la, na + LNG_MAX);
        end
        default: p = make_pair(rand_span(LAT_MAX), rand_span(LNG_MAX),
                               rand_span(LAT_MAX), rand_span(LNG_MAX));
      endcase
      add_pair(p);
    end
    stim_done = 1'b1;
  end

  // Reset and cycle counter with timeout.
  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Driver: random gap before each transaction, predicts at acceptance.
  int drv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_if.valid <= 1'b0;
      pair_if.lat_a <= '0; pair_if.lng_a <= '0; pair_if.lat_b <= '0; pair_if.lng_b <= '0;
      drv_gap <= 0;
    end else begin
      if (pair_if.valid && pair_if.ready) begin
        expected_dist = {expected_dist,
                         haversine_cm(make_pair(pair_if.lat_a, pair_if.lng_a,
                                                pair_if.lat_b, pair_if.lng_b))};
      end
      if (!pair_if.valid || pair_if.ready) begin
        if (drv_gap > 0) begin
          pair_if.valid <= 1'b0;
          drv_gap <= drv_gap - 1;
        end else if (pending_pairs.size() > 0) begin
          p_send(pending_pairs.pop_front());
          drv_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end else begin
          pair_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic p_send(coord_pair_t p);
    pair_if.valid <= 1'b1;
    pair_if.lat_a <= p.lat_a; pair_if.lng_a <= p.lng_a;
    pair_if.lat_b <= p.lat_b; pair_if.lng_b <= p.lng_b;
  endtask

  // Long hold-off: a stretch of stalled cycles that lets the pipeline fill.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off <= 0;
    end else if (cycles == 400) begin
      hold_off <= 3 * LATENCY;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Receiver: random stalls, and no transactions during the hold-off.
  int rcv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_if.ready <= 1'b0;
      rcv_gap <= 0;
    end else begin
      if (cycles == 400 || hold_off > 0) begin
        dist_if.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap <= rcv_gap - 1;
        dist_if.ready <= 1'b0;
      end else begin
        dist_if.ready <= 1'b1;
        if (dist_if.valid && dist_if.ready)
          rcv_gap <= (cycles % 4000 < 1500) ? 0 : $urandom_range(12);
      end
    end
  end

  // Monitor: compare each distance transaction with the oldest prediction.
  always @(posedge clk_i) begin
    logic [30:0] want;
    if (rst_ni && dist_if.valid && dist_if.ready) begin
      if (expected_dist.size() == 0) begin
        if (mismatches < 10) $display("unexpected distance %0d", dist_if.distance_cm);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_dist.pop_front();
        if (dist_if.distance_cm !== want) begin
          if (mismatches < 10)
            $display("distance mismatch: expected %0d actual %0d", want, dist_if.distance_cm);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // End of run: drain, then wait out the pipeline latency.
  initial begin
    mismatches = 0;
    cycles = 0;
    wait (stim_done);
    wait (pending_pairs.size() == 0 && !pair_if.valid);
    wait (expected_dist.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0 && expected_dist.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
